/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/core/edsp_pkg.sv */
// package for the embedded dna stream parser: widths, codes and marker tables
package edsp_pkg;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int STATUS_W    = 3;
	localparam int CODE_W      = 3;

	localparam logic [STATUS_W-1:0] ST_BASE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_END_MARK = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EOF_END  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_DNA   = 3'd4;

	localparam logic [CODE_W-1:0] BC_A   = 3'd0;
	localparam logic [CODE_W-1:0] BC_C   = 3'd1;
	localparam logic [CODE_W-1:0] BC_G   = 3'd2;
	localparam logic [CODE_W-1:0] BC_T   = 3'd3;
	localparam logic [CODE_W-1:0] BC_N   = 3'd4;
	localparam logic [CODE_W-1:0] BC_GAP = 3'd5;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_EOF  = 1'b1;

	localparam logic [3:0] HDR_LEN = 4'd5;
	localparam logic [3:0] END_LEN = 4'd9;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_E    = 8'h65;
	localparam logic [7:0] CH_LF   = 8'h0a;

	// "##DNA"
	function automatic logic [7:0] hdr_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = CH_HASH;
			4'd1: c = CH_HASH;
			4'd2: c = 8'h44;
			4'd3: c = 8'h4e;
			4'd4: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "##end-DNA"
	function automatic logic [7:0] end_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = CH_HASH;
			4'd1: c = CH_HASH;
			4'd2: c = CH_E;
			4'd3: c = 8'h6e;
			4'd4: c = 8'h64;
			4'd5: c = 8'h2d;
			4'd6: c = 8'h44;
			4'd7: c = 8'h4e;
			4'd8: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return b inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
	endfunction

	// base letter lookup, hit flag in the top bit
	function automatic logic [CODE_W:0] base_of(input logic [7:0] b);
		logic [CODE_W:0] r;
		case (b)
			8'h61, 8'h41: r = {1'b1, BC_A};
			8'h63, 8'h43: r = {1'b1, BC_C};
			8'h67, 8'h47: r = {1'b1, BC_G};
			8'h74, 8'h54: r = {1'b1, BC_T};
			8'h6e, 8'h4e: r = {1'b1, BC_N};
			8'h2d:        r = {1'b1, BC_GAP};
			default:      r = {1'b0, BC_A};
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/embedded_dna_stream_parser_unit.sv */
// embedded dna stream parser: input word register, per-byte parse logic, result register
//
//  channel  | dir | tdata                         | tuser          | tlast
//  s_axis   | in  | [7:0] byte_value              | [0] kind       | -
//  m_axis   | out | [2:0] base_code [10:3] bad_byte, rest zero | [2:0] status | -
//
// one word per cycle sustained while m_axis does not stall; a word is held in the input register
// and its result is then written to the result register behind the parse logic
// words that give no result pass the second stage without occupying the result register
// arst_n clears the parse state, both valid flags and returns to header search
// a stall on m_axis holds the result; s_axis stays ready while the input stage can move on
module embedded_dna_stream_parser_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [edsp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] byte_value
	input  logic                              s_axis_tuser,  // [0] kind
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [edsp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [2:0] base_code, [10:3] bad_byte
	output logic [edsp_pkg::STATUS_W-1:0]     m_axis_tuser   // [2:0] status
);
	import edsp_pkg::*;

	localparam logic [2:0] PH_HDR_MATCH   = 3'd0;
	localparam logic [2:0] PH_HDR_SKIP    = 3'd1;
	localparam logic [2:0] PH_DNA_HDRLINE = 3'd2;
	localparam logic [2:0] PH_DNA_START   = 3'd3;
	localparam logic [2:0] PH_DNA_SKIP    = 3'd4;
	localparam logic [2:0] PH_DATA        = 3'd5;
	localparam logic [2:0] PH_DONE        = 3'd6;

	logic              s1_valid_q;
	logic              kind_s1;
	logic [7:0]        byte_s1;
	logic [2:0]        phase_q;
	logic [3:0]        pos_q;
	logic              out_valid_q;
	logic [STATUS_W-1:0] status_s2;
	logic [CODE_W-1:0] code_s2;
	logic [7:0]        bad_s2;

	logic              adv;
	logic [2:0]        phase_n;
	logic [3:0]        pos_n;
	logic              res;
	logic [STATUS_W-1:0] st_n;
	logic [CODE_W-1:0] code_n;
	logic [7:0]        bad_n;
	logic [CODE_W:0]   bl;

	assign adv           = s1_valid_q & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~s1_valid_q | adv;

	assign bl = base_of(byte_s1);

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		res     = 1'b0;
		st_n    = ST_BASE;
		code_n  = BC_A;
		bad_n   = 8'h00;
		if (phase_q >= PH_DONE) begin
			// finished, ignore everything
		end else if (kind_s1 == KIND_EOF) begin
			phase_n = PH_DONE;
			pos_n   = 4'd0;
			res     = 1'b1;
			if (phase_q == PH_HDR_MATCH || phase_q == PH_HDR_SKIP) begin
				st_n = ST_NO_DNA;
			end else if (phase_q == PH_DNA_START && pos_q >= 4'd3) begin
				st_n  = ST_BAD;
				bad_n = CH_E;
			end else begin
				st_n = ST_EOF_END;
			end
		end else begin
			case (phase_q)
				PH_HDR_MATCH: begin
					if (pos_q < HDR_LEN && byte_s1 == hdr_char(pos_q)) begin
						if (pos_q + 4'd1 >= HDR_LEN) begin
							phase_n = PH_DNA_HDRLINE;
							pos_n   = 4'd0;
						end else begin
							pos_n = pos_q + 4'd1;
						end
					end else if (byte_s1 == CH_LF) begin
						pos_n = 4'd0;
					end else begin
						phase_n = PH_HDR_SKIP;
						pos_n   = 4'd0;
					end
				end
				PH_HDR_SKIP: begin
					if (byte_s1 == CH_LF) begin
						phase_n = PH_HDR_MATCH;
						pos_n   = 4'd0;
					end
				end
				PH_DNA_HDRLINE, PH_DNA_SKIP: begin
					if (byte_s1 == CH_LF) begin
						phase_n = PH_DNA_START;
						pos_n   = 4'd0;
					end
				end
				PH_DNA_START: begin
					if (pos_q < 4'd2) begin
						if (byte_s1 == CH_HASH) begin
							pos_n = pos_q + 4'd1;
						end else if (byte_s1 == CH_LF) begin
							pos_n = 4'd0;
						end else begin
							phase_n = PH_DNA_SKIP;
							pos_n   = 4'd0;
						end
					end else if (pos_q == 4'd2 && byte_s1 == CH_E) begin
						pos_n = 4'd3;
					end else if (pos_q == 4'd2) begin
						// first data byte of a plain "##" line
						pos_n = 4'd0;
						if (bl[CODE_W]) begin
							phase_n = PH_DATA;
							res     = 1'b1;
							code_n  = bl[CODE_W-1:0];
						end else if (byte_s1 == CH_LF) begin
							phase_n = PH_DNA_START;
						end else if (is_ws(byte_s1)) begin
							phase_n = PH_DATA;
						end else begin
							phase_n = PH_DONE;
							res     = 1'b1;
							st_n    = ST_BAD;
							bad_n   = byte_s1;
						end
					end else if (pos_q < END_LEN && byte_s1 == end_char(pos_q)) begin
						if (pos_q + 4'd1 >= END_LEN) begin
							phase_n = PH_DONE;
							pos_n   = 4'd0;
							res     = 1'b1;
							st_n    = ST_END_MARK;
						end else begin
							pos_n = pos_q + 4'd1;
						end
					end else begin
						// partial end marker
						phase_n = PH_DONE;
						pos_n   = 4'd0;
						res     = 1'b1;
						st_n    = ST_BAD;
						bad_n   = CH_E;
					end
				end
				PH_DATA: begin
					if (bl[CODE_W]) begin
						res    = 1'b1;
						code_n = bl[CODE_W-1:0];
					end else if (byte_s1 == CH_LF) begin
						phase_n = PH_DNA_START;
						pos_n   = 4'd0;
					end else if (!is_ws(byte_s1)) begin
						phase_n = PH_DONE;
						res     = 1'b1;
						st_n    = ST_BAD;
						bad_n   = byte_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			phase_q     <= PH_HDR_MATCH;
			pos_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (adv) begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
			end
			if (adv && res) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
		if (adv && res) begin
			status_s2 <= st_n;
			code_s2   <= code_n;
			bad_s2    <= bad_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W - CODE_W - 8){1'b0}}, bad_s2, code_s2};

endmodule

/* rtl/core/edsp_checker.sv */
// port-level checker for the embedded dna stream parser, bound to the top level
`include "assert_macros.svh"

module edsp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [edsp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [edsp_pkg::STATUS_W-1:0]     m_axis_tuser
);
	import edsp_pkg::*;

	logic final_seen_q;
	logic in_seen_q;
	logic out_stall;
	logic fields_ok;
	logic [OUT_TDATA_W+STATUS_W-1:0] out_word;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word  = {m_axis_tuser, m_axis_tdata};

	// field contents allowed for each status, padding always zero
	always_comb begin
		case (m_axis_tuser)
			ST_BASE: fields_ok = m_axis_tdata[10:3] == 8'h00 && m_axis_tdata[2:0] <= BC_GAP;
			ST_BAD: fields_ok = m_axis_tdata[2:0] == BC_A;
			ST_END_MARK, ST_EOF_END, ST_NO_DNA: fields_ok = m_axis_tdata[10:0] == 11'd0;
			default: fields_ok = 1'b0;
		endcase
		if (m_axis_tdata[OUT_TDATA_W-1:11] != '0) begin
			fields_ok = 1'b0;
		end
	end

	// final_seen_q is set once a terminating result word has been taken, in_seen_q once an input word has
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_seen_q <= 1'b0;
			in_seen_q    <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && m_axis_tuser != ST_BASE) begin
				final_seen_q <= 1'b1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				in_seen_q <= 1'b1;
			end
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word))
	`ASSERT_IMPL(a_no_out_after_final, clk, arst_n, final_seen_q, !m_axis_tvalid)
	`ASSERT_IMPL(a_no_out_before_in, clk, arst_n, !in_seen_q, !m_axis_tvalid)
	`ASSERT_IMPL(a_fields_clean, clk, arst_n, m_axis_tvalid, fields_ok)

endmodule

bind embedded_dna_stream_parser_unit edsp_checker u_edsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

/* bench/embedded_dna_stream_parser_unit_tb.sv */
// testbench for the embedded dna stream parser: result scoreboard, stream drivers and checks
`timescale 1ns / 1ps

typedef enum logic [3:0] {
	SEEK_HDR,
	SKIP_PRE,
	SKIP_HDR_LINE,
	LINE_START,
	SKIP_LINE,
	IN_DATA,
	FINISHED
} parse_phase_t;

typedef struct packed {
	logic [edsp_pkg::STATUS_W-1:0] status;
	logic [edsp_pkg::CODE_W-1:0]   code;
	logic [7:0]                    bad;
} dna_result_t;

localparam logic [39:0] HEADER_TAG = "##DNA";
localparam logic [71:0] END_TAG    = "##end-DNA";

function automatic logic [7:0] header_char(int idx);
	return HEADER_TAG[8*(4-idx) +: 8];
endfunction

function automatic logic [7:0] end_tag_char(int idx);
	return END_TAG[8*(8-idx) +: 8];
endfunction

// -1 when the byte is no base letter
function automatic int base_code_of(logic [7:0] b);
	case (b)
		"a", "A": return int'(edsp_pkg::BC_A);
		"c", "C": return int'(edsp_pkg::BC_C);
		"g", "G": return int'(edsp_pkg::BC_G);
		"t", "T": return int'(edsp_pkg::BC_T);
		"n", "N": return int'(edsp_pkg::BC_N);
		"-":      return int'(edsp_pkg::BC_GAP);
		default:  return -1;
	endcase
endfunction

function automatic bit is_blank(logic [7:0] b);
	return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c || b == 8'h0d;
endfunction

class dna_scoreboard;
	parse_phase_t  phase;
	int            mpos;
	dna_result_t   expected_q[$];
	int            errors;
	int            results_seen;
	int            words_noted;
	logic [2:0]    last_status;

	function new();
		phase = SEEK_HDR;
		mpos = 0;
		errors = 0;
		results_seen = 0;
		words_noted = 0;
		last_status = '0;
	endfunction

	function bit is_finished();
		return phase == FINISHED;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void add_expected(logic [2:0] s, logic [2:0] c, logic [7:0] bd);
		dna_result_t r;
		r.status = s;
		r.code = c;
		r.bad = bd;
		expected_q.push_back(r);
	endfunction

	// one byte of a "##" line after the two hashes
	function void data_char(logic [7:0] b);
		int code;
		code = base_code_of(b);
		if (code >= 0) begin
			phase = IN_DATA;
			add_expected(edsp_pkg::ST_BASE, code[2:0], 8'h00);
		end else if (b == edsp_pkg::CH_LF) begin
			phase = LINE_START;
			mpos = 0;
		end else if (is_blank(b)) begin
			phase = IN_DATA;
		end else begin
			phase = FINISHED;
			add_expected(edsp_pkg::ST_BAD, '0, b);
		end
	endfunction

	function void note_word(logic k, logic [7:0] b);
		if (phase == FINISHED)
			return;
		words_noted++;
		if (k == edsp_pkg::KIND_EOF) begin
			if (phase == SEEK_HDR || phase == SKIP_PRE)
				add_expected(edsp_pkg::ST_NO_DNA, '0, 8'h00);
			else if (phase == LINE_START && mpos >= 3)
				add_expected(edsp_pkg::ST_BAD, '0, edsp_pkg::CH_E);
			else
				add_expected(edsp_pkg::ST_EOF_END, '0, 8'h00);
			phase = FINISHED;
			mpos = 0;
			return;
		end
		case (phase)
			SEEK_HDR: begin
				if (mpos < 5 && b == header_char(mpos)) begin
					mpos++;
					if (mpos == 5) begin
						phase = SKIP_HDR_LINE;
						mpos = 0;
					end
				end else if (b == edsp_pkg::CH_LF) begin
					mpos = 0;
				end else begin
					phase = SKIP_PRE;
					mpos = 0;
				end
			end
			SKIP_PRE: begin
				if (b == edsp_pkg::CH_LF) begin
					phase = SEEK_HDR;
					mpos = 0;
				end
			end
			SKIP_HDR_LINE, SKIP_LINE: begin
				if (b == edsp_pkg::CH_LF) begin
					phase = LINE_START;
					mpos = 0;
				end
			end
			LINE_START: begin
				if (mpos < 2) begin
					if (b == edsp_pkg::CH_HASH) begin
						mpos++;
					end else if (b == edsp_pkg::CH_LF) begin
						mpos = 0;
					end else begin
						phase = SKIP_LINE;
						mpos = 0;
					end
				end else if (mpos == 2) begin
					if (b == edsp_pkg::CH_E) begin
						mpos = 3;
					end else begin
						mpos = 0;
						data_char(b);
					end
				end else if (b == end_tag_char(mpos)) begin
					mpos++;
					if (mpos == 9) begin
						phase = FINISHED;
						mpos = 0;
						add_expected(edsp_pkg::ST_END_MARK, '0, 8'h00);
					end
				end else begin
					// end marker started but broke off
					phase = FINISHED;
					mpos = 0;
					add_expected(edsp_pkg::ST_BAD, '0, edsp_pkg::CH_E);
				end
			end
			IN_DATA: data_char(b);
			default: ;
		endcase
	endfunction

	function void check_result(logic [2:0] s, logic [2:0] c, logic [7:0] bd);
		dna_result_t want;
		results_seen++;
		last_status = s;
		if (expected_q.size() == 0) begin
			$error("result word with nothing expected: status %0d base_code %0d bad_byte %0d",
				s, c, bd);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (s !== want.status) begin
			$error("status: expected %0d actual %0d", want.status, s);
			errors++;
		end
		if (c !== want.code) begin
			$error("base_code: expected %0d actual %0d", want.code, c);
			errors++;
		end
		if (bd !== want.bad) begin
			$error("bad_byte: expected %0d actual %0d", want.bad, bd);
			errors++;
		end
	endfunction
endclass

module embedded_dna_stream_parser_unit_tb;
	import edsp_pkg::*;

	typedef enum int {
		END_BY_MARKER,
		END_BY_EOF,
		END_BY_BAD_CHAR,
		END_BY_CUT_MARKER,
		END_BY_NO_HEADER
	} stream_end_t;

	localparam int STREAM_WORDS = 750;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;   // [7:0] byte_value
	logic                    s_axis_tuser;   // [0] kind
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // [2:0] base_code, [10:3] bad_byte
	logic [STATUS_W-1:0]     m_axis_tuser;   // [2:0] status

	dna_scoreboard sb;
	stream_end_t   ending;
	bit            src_calm;
	bit            sink_calm;
	bit            paused_once;
	int            idle_cycles = 0;

	embedded_dna_stream_parser_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] pick_byte_except(logic [7:0] a, logic [7:0] b);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == a || v == b);
		return v;
	endfunction

	function automatic logic [7:0] pick_data_char();
		int idx;
		idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 10) : $urandom_range(11, 15);
		case (idx)
			0: return "a";
			1: return "A";
			2: return "c";
			3: return "C";
			4: return "g";
			5: return "G";
			6: return "t";
			7: return "T";
			8: return "n";
			9: return "N";
			10: return "-";
			11: return 8'h20;
			12: return 8'h09;
			13: return 8'h0d;
			14: return 8'h0b;
			default: return 8'h0c;
		endcase
	endfunction

	function automatic logic [7:0] pick_bad_char();
		logic [7:0] v;
		do begin
			if ($urandom_range(0, 3) == 0)
				v = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(128, 255));
			else
				v = 8'($urandom_range(0, 255));
		end while (base_code_of(v) >= 0 || is_blank(v));
		return v;
	endfunction

	task automatic send_word(input logic k, input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 49) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= k;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_word(k, b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(KIND_BYTE, s[i]);
	endtask

	// hold the sender until every expected result is out
	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_noise_tail(input int n);
		for (int i = 0; i < n; i++)
			send_word(KIND_BYTE, pick_byte_except(CH_LF, CH_LF));
		send_word(KIND_BYTE, CH_LF);
	endtask

	task automatic send_noise_line(input int n);
		send_word(KIND_BYTE, pick_byte_except(CH_HASH, CH_LF));
		send_noise_tail(n);
	endtask

	task automatic send_data_chars(input int n);
		for (int i = 0; i < n; i++)
			send_word(KIND_BYTE, pick_data_char());
	endtask

	task automatic send_data_line(input int n);
		send_text("##");
		send_data_chars(n);
		send_word(KIND_BYTE, CH_LF);
	endtask

	function automatic int line_length();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(80, 150) : $urandom_range(0, 30);
	endfunction

	task automatic send_partial_header();
		int n;
		logic [7:0] b;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			send_word(KIND_BYTE, header_char(i));
		b = pick_byte_except(header_char(n), header_char(n));
		send_word(KIND_BYTE, b);
		if (b != CH_LF)
			send_noise_tail($urandom_range(0, 20));
	endtask

	task automatic run_directed();
		if (ending == END_BY_NO_HEADER) begin
			send_text("#D\n");
			send_text("##DN\n");
			send_text("##DNa\n");
		end else begin
			send_text("##DNA x\n");
			send_text("##aAcCgGtTnN- \t\r");
			send_word(KIND_BYTE, 8'h0b);
			send_word(KIND_BYTE, 8'h0c);
			send_word(KIND_BYTE, CH_LF);
		end
	endtask

	task automatic run_random();
		int pick;
		while (sb.words_noted < STREAM_WORDS && !sb.is_finished()) begin
			if (!paused_once && sb.words_noted >= STREAM_WORDS / 2) begin
				paused_once = 1'b1;
				drain_pause();
			end else if ($urandom_range(0, 39) == 0) begin
				drain_pause();
			end
			if (ending == END_BY_NO_HEADER) begin
				pick = $urandom_range(0, 3);
				case (pick)
					0, 1: send_noise_line(line_length());
					2: send_partial_header();
					default: send_word(KIND_BYTE, CH_LF);
				endcase
			end else begin
				pick = $urandom_range(0, 19);
				if (pick <= 13) begin
					send_data_line(line_length());
				end else if (pick <= 15) begin
					send_noise_line(line_length());
				end else if (pick == 16) begin
					send_word(KIND_BYTE, CH_LF);
				end else if (pick == 17) begin
					// single hash, then an ordinary line
					send_word(KIND_BYTE, CH_HASH);
					send_noise_line($urandom_range(0, 10));
				end else if (pick == 18) begin
					send_text("##\n");
				end else begin
					send_text("#\n");
				end
			end
		end
	endtask

	task automatic close_stream();
		int n;
		int how;
		case (ending)
			END_BY_MARKER: send_text("##end-DNA");
			END_BY_EOF: begin
				how = $urandom_range(0, 2);
				if (how == 1) begin
					send_text("##");
					send_data_chars($urandom_range(0, 8));
				end else if (how == 2) begin
					send_word(KIND_BYTE, CH_HASH);
				end
				send_word(KIND_EOF, 8'($urandom_range(0, 255)));
			end
			END_BY_BAD_CHAR: begin
				send_text("##");
				send_data_chars($urandom_range(0, 8));
				send_word(KIND_BYTE, pick_bad_char());
			end
			END_BY_CUT_MARKER: begin
				n = $urandom_range(3, 8);
				for (int i = 0; i < n; i++)
					send_word(KIND_BYTE, end_tag_char(i));
				how = $urandom_range(0, 2);
				if (how == 0)
					send_word(KIND_EOF, 8'($urandom_range(0, 255)));
				else if (how == 1)
					send_word(KIND_BYTE, CH_LF);
				else
					send_word(KIND_BYTE, pick_byte_except(end_tag_char(n), end_tag_char(n)));
			end
			default: begin
				if ($urandom_range(0, 1) == 0) begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						send_word(KIND_BYTE, header_char(i));
				end
				send_word(KIND_EOF, 8'($urandom_range(0, 255)));
			end
		endcase
		// everything after the final result must be dropped silently
		send_text("##acgt\n##end-DNA\n");
		for (int i = 0; i < 16; i++)
			send_word(($urandom_range(0, 3) == 0) ? KIND_EOF : KIND_BYTE,
				8'($urandom_range(0, 255)));
	endtask

	initial begin
		int r;
		sb = new();
		src_calm = 1'b0;
		paused_once = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= KIND_BYTE;
		r = $urandom_range(0, 9);
		if (r == 0)
			ending = END_BY_NO_HEADER;
		else if (r <= 2)
			ending = END_BY_MARKER;
		else if (r <= 4)
			ending = END_BY_EOF;
		else if (r <= 6)
			ending = END_BY_BAD_CHAR;
		else
			ending = END_BY_CUT_MARKER;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		close_stream();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("fed %0d parsed words, checked %0d result words", sb.words_noted,
			sb.results_seen);
		$display("stream closed via %s, last status %0d", ending.name(), sb.last_status);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// result side with random back-pressure
	initial begin
		int gap;
		sink_calm = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				sink_calm = !sink_calm;
			gap = sink_calm ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
			sb.check_result(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3]);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
